// ===== rtl/ciau_pkg.sv =====
// Package for the checked 64-bit integer ALU: opcodes, status codes,
// controller/datapath command and status types.
// No dependencies.
package ciau_pkg;

  typedef enum logic [3:0] {
    OP_POS   = 4'd0,
    OP_NEG   = 4'd1,
    OP_INV   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_FDIV  = 4'd6,
    OP_MOD   = 4'd7,
    OP_POW   = 4'd8,
    OP_AND   = 4'd9,
    OP_OR    = 4'd10,
    OP_XOR   = 4'd11,
    OP_SHL   = 4'd12,
    OP_SHR   = 4'd13
  } op_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVF      = 3'd1;
  localparam logic [2:0] ST_DIV0     = 3'd2;
  localparam logic [2:0] ST_NEGSHIFT = 3'd3;
  localparam logic [2:0] ST_NEGEXP   = 3'd4;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam int          SHIFT_LIMIT = 63;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_START,
    DP_MUL_STEP,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_ACC_LOAD,
    DP_BASE_LOAD
  } dp_op_t;

  typedef enum logic [1:0] {
    MS_AB,
    MS_SHL,
    MS_ACC,
    MS_SQ
  } mul_src_t;

  typedef enum logic [2:0] {
    FIN_QUICK,
    FIN_MUL,
    FIN_DIV,
    FIN_POW,
    FIN_OVF
  } fin_src_t;

  typedef struct packed {
    dp_op_t   op;
    logic     e_shift;
    logic     fin;
    mul_src_t msrc;
    fin_src_t fsrc;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic mul_last;
    logic div_last;
    logic mul_ok;
    logic e_zero;
    logic e_lsb;
    logic b_neg;
    logic b_zero;
    logic b_ge63;
    logic div_ovf;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_MUL_END,
    S_DIV,
    S_POW_CHECK,
    S_POW_SHIFT,
    S_POW_AFTER,
    S_FIN
  } state_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ===== rtl/ciau_dp.sv =====
// Datapath of the checked ALU: operand registers, 64x16 multiply
// accumulator, restoring divider, power registers and result register.
// Depends on ciau_pkg.
module ciau_dp (
  input  logic               clk,
  input  ciau_pkg::dp_cmd_t  cmd,
  input  logic [3:0]         req_type,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output ciau_pkg::dp_stat_t stat,
  output logic signed [63:0] result_value,
  output logic [2:0]         status
);
  import ciau_pkg::*;

  op_t          op;
  logic [63:0]  a, b, acc, base, e;
  logic [63:0]  mx, my;
  logic         mneg;
  logic [127:0] prod;
  logic [1:0]   k;
  logic [63:0]  rem, quo, den;
  logic [5:0]   cnt;

  // multiplier operand select
  logic [63:0]  sel_x, sel_y;
  always_comb begin
    case (cmd.msrc)
      MS_AB:   begin sel_x = a;    sel_y = b; end
      MS_SHL:  begin sel_x = a;    sel_y = 64'd1 << b[5:0]; end
      MS_ACC:  begin sel_x = acc;  sel_y = base; end
      MS_SQ:   begin sel_x = base; sel_y = base; end
      default: begin sel_x = a;    sel_y = b; end
    endcase
  end

  // partial product of one 16-bit slice
  logic [79:0]  part;
  logic [127:0] part_sh;
  assign part    = mx * my[16*k +: 16];
  assign part_sh = {48'd0, part} << {k, 4'd0};

  // signed product and its range check
  logic [63:0] plo, mul_val;
  logic        mul_ok;
  assign plo     = prod[63:0];
  assign mul_ok  = (prod[127:64] == 64'd0) && (mneg ? (plo <= SIGN_BIT) : (plo < SIGN_BIT));
  assign mul_val = mneg ? (64'd0 - plo) : plo;

  // one restoring division step
  logic [63:0] rsh;
  logic [64:0] trial;
  assign rsh   = {rem[62:0], quo[63]};
  assign trial = {1'b0, rsh} - {1'b0, den};

  // floor correction of quotient / remainder
  logic        an, bn, r_nz;
  logic [63:0] div_val, mod_val;
  assign an   = a[63];
  assign bn   = b[63];
  assign r_nz = (rem != 64'd0);
  always_comb begin
    mod_val = an ? (64'd0 - rem) : rem;
    if (r_nz && (an != bn)) mod_val = mod_val + b;
    if (an != bn) div_val = 64'd0 - (quo + {63'd0, r_nz});
    else          div_val = quo;
  end

  // quick operations and early failures
  logic [63:0] q_val, sum, dif;
  logic [2:0]  q_st;
  logic        b_ge63;
  assign sum    = a + b;
  assign dif    = a - b;
  assign b_ge63 = (b[62:6] != 57'd0) || (b[5:0] == 6'd63);
  always_comb begin
    q_val = 64'd0;
    q_st  = ST_OK;
    case (op)
      OP_POS: q_val = a;
      OP_NEG: begin
        if (a == SIGN_BIT) q_st = ST_OVF;
        else q_val = 64'd0 - a;
      end
      OP_INV: q_val = ~a;
      OP_ADD: begin
        q_val = sum;
        if ((an == bn) && (sum[63] != an)) q_st = ST_OVF;
      end
      OP_SUB: begin
        q_val = dif;
        if ((an != bn) && (dif[63] != an)) q_st = ST_OVF;
      end
      OP_FDIV, OP_MOD: q_st = (b == 64'd0) ? ST_DIV0 : ST_OVF;
      OP_POW: q_st = ST_NEGEXP;
      OP_AND: q_val = a & b;
      OP_OR:  q_val = a | b;
      OP_XOR: q_val = a ^ b;
      OP_SHL: q_st = bn ? ST_NEGSHIFT : ST_OVF;
      OP_SHR: begin
        if (bn) q_st = ST_NEGSHIFT;
        else if (b_ge63) q_val = {64{an}};
        else q_val = $unsigned($signed(a) >>> b[5:0]);
      end
      default: q_val = 64'd0;
    endcase
    if (q_st != ST_OK) q_val = 64'd0;
  end

  // register updates
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op   <= op_t'(req_type);
        a    <= operand_a;
        b    <= operand_b;
        acc  <= 64'd1;
        base <= operand_a;
        e    <= operand_b;
      end
      DP_MUL_START: begin
        mx   <= mag(sel_x);
        my   <= mag(sel_y);
        mneg <= sel_x[63] ^ sel_y[63];
        prod <= 128'd0;
        k    <= 2'd0;
      end
      DP_MUL_STEP: begin
        prod <= prod + part_sh;
        k    <= k + 2'd1;
      end
      DP_DIV_START: begin
        rem <= 64'd0;
        quo <= mag(a);
        den <= mag(b);
        cnt <= 6'd0;
      end
      DP_DIV_STEP: begin
        if (!trial[64]) rem <= trial[63:0];
        else            rem <= rsh;
        quo <= {quo[62:0], ~trial[64]};
        cnt <= cnt + 6'd1;
      end
      DP_ACC_LOAD:  acc  <= mul_val;
      DP_BASE_LOAD: base <= mul_val;
      default: ;
    endcase
    if (cmd.e_shift) e <= {1'b0, e[63:1]};
    // result register
    if (cmd.fin) begin
      case (cmd.fsrc)
        FIN_QUICK: begin result_value <= q_val; status <= q_st; end
        FIN_MUL: begin
          result_value <= mul_ok ? mul_val : 64'd0;
          status       <= mul_ok ? ST_OK : ST_OVF;
        end
        FIN_DIV: begin
          result_value <= (op == OP_MOD) ? mod_val : div_val;
          status       <= ST_OK;
        end
        FIN_POW: begin result_value <= acc; status <= ST_OK; end
        default: begin result_value <= 64'd0; status <= ST_OVF; end
      endcase
    end
  end

  // status to controller
  always_comb begin
    stat.op       = op;
    stat.mul_last = (k == 2'd3);
    stat.div_last = (cnt == 6'd63);
    stat.mul_ok   = mul_ok;
    stat.e_zero   = (e == 64'd0);
    stat.e_lsb    = e[0];
    stat.b_neg    = bn;
    stat.b_zero   = (b == 64'd0);
    stat.b_ge63   = b_ge63;
    stat.div_ovf  = (a == SIGN_BIT) && (b == {64{1'b1}});
  end

endmodule

// ===== rtl/ciau_ctrl.sv =====
// Controller of the checked ALU: sequences multiply, divide and power
// steps and owns the input and output handshakes.
// Depends on ciau_pkg.
module ciau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ciau_pkg::dp_stat_t stat,
  output ciau_pkg::dp_cmd_t  cmd
);
  import ciau_pkg::*;

  state_t   state, state_next;
  fin_src_t fin_src, fin_src_next;
  logic     pow_sq, pow_sq_next;
  logic     out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin_src   <= FIN_QUICK;
      pow_sq    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fin_src <= fin_src_next;
      pow_sq  <= pow_sq_next;
      if (cmd.fin)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    fin_src_next = fin_src;
    pow_sq_next  = pow_sq;
    cmd.op       = DP_NOP;
    cmd.e_shift  = 1'b0;
    cmd.fin      = 1'b0;
    cmd.msrc     = MS_AB;
    cmd.fsrc     = fin_src;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        fin_src_next = FIN_QUICK;
        state_next   = S_FIN;
        case (stat.op)
          OP_MUL: begin
            cmd.op = DP_MUL_START; cmd.msrc = MS_AB; state_next = S_MUL;
          end
          OP_SHL: begin
            if (!stat.b_neg && !stat.b_ge63) begin
              cmd.op = DP_MUL_START; cmd.msrc = MS_SHL; state_next = S_MUL;
            end
          end
          OP_FDIV, OP_MOD: begin
            if (!stat.b_zero && !stat.div_ovf) begin
              cmd.op = DP_DIV_START; state_next = S_DIV;
            end
          end
          OP_POW: begin
            if (!stat.b_neg) state_next = S_POW_CHECK;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_MUL: begin
        cmd.op = DP_MUL_STEP;
        if (stat.mul_last) state_next = S_MUL_END;
      end
      S_MUL_END: begin
        if (stat.op != OP_POW) begin
          fin_src_next = FIN_MUL; state_next = S_FIN;
        end else if (!stat.mul_ok) begin
          fin_src_next = FIN_OVF; state_next = S_FIN;
        end else if (pow_sq) begin
          cmd.op = DP_BASE_LOAD; state_next = S_POW_CHECK;
        end else begin
          cmd.op = DP_ACC_LOAD; state_next = S_POW_SHIFT;
        end
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) begin
          fin_src_next = FIN_DIV; state_next = S_FIN;
        end
      end
      S_POW_CHECK: begin
        if (stat.e_zero) begin
          fin_src_next = FIN_POW; state_next = S_FIN;
        end else if (stat.e_lsb) begin
          cmd.op = DP_MUL_START; cmd.msrc = MS_ACC;
          pow_sq_next = 1'b0; state_next = S_MUL;
        end else begin
          state_next = S_POW_SHIFT;
        end
      end
      S_POW_SHIFT: begin
        cmd.e_shift = 1'b1;
        state_next  = S_POW_AFTER;
      end
      S_POW_AFTER: begin
        if (stat.e_zero) begin
          fin_src_next = FIN_POW; state_next = S_FIN;
        end else begin
          cmd.op = DP_MUL_START; cmd.msrc = MS_SQ;
          pow_sq_next = 1'b1; state_next = S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/checked_int64_alu_unit.sv =====
// Top level of the overflow-checked 64-bit integer ALU with floor division.
// Depends on ciau_pkg, ciau_ctrl, ciau_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  input   | in_valid / in_stall  | req_type, operand_a, operand_b
//  output  | out_valid / out_stall| result_value, status
//
// One item at a time. Quick ops register the result from the finish state after
// dispatch; mul and shl first run four 64x16 multiply-accumulate steps;
// floordiv/mod first run the divider, one quotient bit per cycle. pow runs
// square-and-multiply over the exponent bits on the shared multiplier. The
// next input is taken in the cycle after the result is registered. Synchronous
// active-high reset clears control only. A waiting result sits in the output
// register while the next item is accepted; a further result holds until that
// one transfers.
module checked_int64_alu_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [2:0]         status
);
  import ciau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ciau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ciau_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .req_type     (req_type),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .stat         (stat),
    .result_value (result_value),
    .status       (status)
  );

  // failed results carry a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_value == 64'd0))
    else $error("nonzero value with failure status");

  // one item at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NEGEXP))
    else $error("status code out of range");

endmodule

// ===== sim/checked_int64_alu_checker.sv =====
// Checker for the checked 64-bit integer ALU: watches both channels, predicts
// each result from the accepted request and compares it field by field.
// Depends on ciau_pkg.
module checked_int64_alu_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [63:0] result_value,
  input  logic [2:0]         status,
  output int                 error_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ciau_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  code;
  } alu_result_t;

  alu_result_t result_fifo[$];

  localparam logic [63:0] ALL_ONES = '1;

  assign pending_count = result_fifo.size();

  // Signed multiply with range check; ok is cleared on overflow.
  function automatic logic [63:0] smul(input logic [63:0] a, input logic [63:0] b,
                                       output logic ok);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    logic         neg;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    neg = a[63] ^ b[63];
    p = ua * ub;
    ok = 1'b1;
    if (p[127:64] != 64'd0) ok = 1'b0;
    else if (neg && p[63:0] > SIGN_BIT) ok = 1'b0;
    else if (!neg && p[63:0] >= SIGN_BIT) ok = 1'b0;
    return neg ? -p[63:0] : p[63:0];
  endfunction

  // Expected value and status for one request.
  function automatic alu_result_t predict_alu(input logic [3:0] op, input logic [63:0] a,
                                              input logic [63:0] b);
    alu_result_t res;
    logic [63:0] r, ua, ub, q, rm, acc, base, e;
    logic        ok;
    r = '0;
    res.code = ST_OK;
    case (op)
      OP_POS: r = a;
      OP_NEG: begin
        if (a == SIGN_BIT) res.code = ST_OVF; else r = -a;
      end
      OP_INV: r = ~a;
      OP_ADD: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) res.code = ST_OVF;
      end
      OP_SUB: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) res.code = ST_OVF;
      end
      OP_MUL: begin
        r = smul(a, b, ok);
        if (!ok) res.code = ST_OVF;
      end
      OP_FDIV, OP_MOD: begin
        if (b == 64'd0) res.code = ST_DIV0;
        else if (a == SIGN_BIT && b == ALL_ONES) res.code = ST_OVF;
        else begin
          ua = a[63] ? -a : a;
          ub = b[63] ? -b : b;
          q = ua / ub;
          rm = ua % ub;
          if (op == OP_MOD) begin
            r = a[63] ? -rm : rm;
            if (rm != 64'd0 && a[63] != b[63]) r = r + b;
          end else if (a[63] != b[63]) begin
            r = -(q + {63'd0, rm != 64'd0});
          end else begin
            r = q;
          end
        end
      end
      OP_POW: begin
        // square-and-multiply, stopping at the first overflow
        if (b[63]) res.code = ST_NEGEXP;
        else begin
          acc = 64'd1;
          base = a;
          e = b;
          while (e != 64'd0 && res.code == ST_OK) begin
            if (e[0]) begin
              acc = smul(acc, base, ok);
              if (!ok) res.code = ST_OVF;
            end
            e = e >> 1;
            if (e != 64'd0 && res.code == ST_OK) begin
              base = smul(base, base, ok);
              if (!ok) res.code = ST_OVF;
            end
          end
          r = acc;
        end
      end
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_XOR: r = a ^ b;
      OP_SHL: begin
        if (b[63]) res.code = ST_NEGSHIFT;
        else if (b >= SHIFT_LIMIT) res.code = ST_OVF;
        else begin
          r = smul(a, 64'd1 << b, ok);
          if (!ok) res.code = ST_OVF;
        end
      end
      OP_SHR: begin
        if (b[63]) res.code = ST_NEGSHIFT;
        else if (b >= SHIFT_LIMIT) r = a[63] ? ALL_ONES : '0;
        else r = $signed(a) >>> b;
      end
      default: r = '0;
    endcase
    res.value = (res.code == ST_OK) ? r : '0;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        result_fifo.insert(result_fifo.size(),
                           predict_alu(req_type, operand_a, operand_b));
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          want = result_fifo.pop_front();
          if (result_value !== want.value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      result_value, want.value));
          if (status !== want.code)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.code));
        end
      end
    end
  end

endmodule

// ===== sim/checked_int64_alu_unit_test.sv =====
// Testbench top for checked_int64_alu_unit: drives directed and random
// requests with idle and stall phases; the checker does the comparison.
// Depends on ciau_pkg, checked_int64_alu_unit, checked_int64_alu_checker.
module checked_int64_alu_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ciau_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  // opcodes left unused by the block
  localparam logic [3:0] OP_SPARE_LO = 4'd14;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         req_type;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] result_value;
  logic [2:0]         status;
  int                 error_count;
  int                 pending_count;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 cycle_count;

  checked_int64_alu_unit u_top (.*);

  checked_int64_alu_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand mix: edges, small values, and full-range patterns.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'(signed'($urandom_range(8)) - 4);
      3, 4: return 64'(signed'($urandom_range(200)) - 100);
      5: return 64'(signed'({$urandom()}) >>> $urandom_range(31));
      default: return rand64() >>> $urandom_range(63);
    endcase
  endfunction

  // Send one request, idling first at random; hold until accepted.
  task automatic send(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [3:0]  op;
    logic [63:0] a, b;
    op = 4'($urandom_range(15));
    a = $urandom_range(3) == 0 ? rand64() : pick_operand();
    b = $urandom_range(3) == 0 ? rand64() : pick_operand();
    if (op == OP_POW && $urandom_range(3) != 0) b = 64'($urandom_range(70));
    if ((op == OP_SHL || op == OP_SHR) && $urandom_range(3) != 0)
      b = 64'($urandom_range(70));
    send(op, a, b);
  endtask

  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG1  = '1;

  initial begin
    in_valid = 1'b0;
    req_type = '0;
    operand_a = '0;
    operand_b = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and each special case.
    send(OP_POS, MIN_V, 64'd0);
    send(OP_NEG, MIN_V, 64'd0);
    send(OP_NEG, MAX_V, 64'd0);
    send(OP_INV, NEG1, MAX_V);
    send(OP_ADD, MAX_V, 64'd1);
    send(OP_SUB, MIN_V, 64'd1);
    send(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
    send(OP_MUL, -64'h1_0000_0000, 64'h8000_0000);
    send(OP_FDIV, 64'd7, 64'd0);
    send(OP_MOD, -64'd7, 64'd2);
    send(OP_FDIV, -64'd7, 64'd2);
    send(OP_MOD, MIN_V, NEG1);
    send(OP_FDIV, MIN_V, NEG1);
    send(OP_POW, 64'd0, 64'd0);
    send(OP_POW, 64'd3, 64'd39);
    send(OP_POW, 64'd3, 64'd40);
    send(OP_POW, 64'd2, NEG1);
    send(OP_AND, NEG1, MIN_V);
    send(OP_OR, MIN_V, 64'd1);
    send(OP_XOR, MAX_V, NEG1);
    send(OP_SHL, 64'd1, 64'd63);
    send(OP_SHL, 64'd1, 64'd62);
    send(OP_SHL, 64'd5, NEG1);
    send(OP_SHR, MIN_V, 64'd63);
    send(OP_SHR, -64'd5, 64'd1);
    send(OP_SPARE_LO, MAX_V, MAX_V);
    send(OP_SPARE_HI, NEG1, NEG1);

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 30 : 0;
      repeat (138) send_random();
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
